// ----- design/cpp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and arithmetic steps of the capsule point push-out
// Word formats, derived widths and the per-stage steps of the three
// iterative chains (fraction divide, square root, offset divide).
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Field formats
  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RadW     = 24;
  localparam int unsigned TBits    = 24;

  // Derived widths
  localparam int unsigned SW      = CoordW + 1;        // b - a, p - a
  localparam int unsigned MagW    = CoordW + 1;        // magnitudes
  localparam int unsigned ProdW   = 2 * MagW;
  localparam int unsigned SumW    = ProdW + 2;         // sum of three products
  localparam int unsigned DotW    = SumW + 1;
  localparam int unsigned RemW    = SumW + 1;
  localparam int unsigned OfpW    = MagW + TBits + 2;
  localparam int unsigned RpW     = RadW + TBits + 1;
  localparam int unsigned CenW    = CoordW + 1;
  localparam int unsigned DiffW   = CoordW + 2;
  localparam int unsigned MdW     = RadW + 1;
  localparam int unsigned MdSqW   = 2 * MdW;
  localparam int unsigned SqShift = 12;
  localparam int unsigned SqInW   = MdSqW + SqShift;
  localparam int unsigned SqSteps = SqInW / 2;
  localparam int unsigned RootW   = SqSteps;
  localparam int unsigned SqRemW  = RootW + 3;
  localparam int unsigned OffFrac = 6;
  localparam int unsigned NumW    = 2 * MdW;
  localparam int unsigned NnW     = NumW + OffFrac + 1;
  localparam int unsigned QBits   = MdW + 1;
  localparam int unsigned QRemW   = NnW - QBits;
  localparam int unsigned OutSumW = CenW + 2;

  // Squared distance below which a length counts as zero
  localparam longint unsigned MinDistSq =
    ((64'd1 << (2 * FracBits)) + 64'd5000) / 64'd10000;

  // Pipeline depth: front, fraction divide, centre/distance, root, offset divide, out
  localparam int unsigned NumStages =
    3 + (TBits + 1) + 5 + (SqSteps + 1) + 1 + (QBits + 1) + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [RadW-1:0]   rad_t;
  typedef logic signed [SW-1:0]     sd_t;
  typedef logic        [MagW-1:0]   mag_t;
  typedef logic        [ProdW-1:0]  prod_t;
  typedef logic        [SumW-1:0]   sum_t;
  typedef logic signed [DotW-1:0]   dot_t;
  typedef logic        [RemW-1:0]   rem_t;
  typedef logic signed [CenW-1:0]   cen_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [MdW-1:0]    md_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   pinned;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    rad_t   a_radius;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    rad_t   b_radius;
  } in_word_t;

  typedef struct packed {
    coord_t new_x;
    coord_t new_y;
    coord_t new_z;
    logic   pushed;
  } out_word_t;

  // Item context carried through the front half
  typedef struct packed {
    coord_t [2:0] p;
    coord_t [2:0] a;
    rad_t         ra;
    rad_t         rb;
    logic         pinned;
  } ctx_t;

  typedef struct packed {
    ctx_t      ctx;
    sd_t [2:0] s;
    sd_t [2:0] v;
  } st1_t;

  typedef struct packed {
    ctx_t        ctx;
    sd_t [2:0]   s;
    prod_t [2:0] sq;
    prod_t [2:0] pr;
    logic [2:0]  prn;
  } st2_t;

  typedef struct packed {
    ctx_t      ctx;
    sd_t [2:0] s;
    sum_t      seg;
    dot_t      dot;
  } st3_t;

  typedef struct packed {
    ctx_t             ctx;
    sd_t [2:0]        s;
    sum_t             seg;
    rem_t             rem;
    logic [TBits-1:0] quo;
    logic             degen;
    logic             tzero;
    logic             tone;
  } tdiv_t;

  typedef struct packed {
    ctx_t                  ctx;
    logic [2:0]            sneg;
    logic [2:0][OfpW-1:0]  ofp;
    logic                  rbge;
    logic [RpW-1:0]        rp;
    logic                  degen;
  } c1_t;

  typedef struct packed {
    coord_t [2:0] p;
    logic         pinned;
    cen_t [2:0]   cen;
    rad_t         rad;
  } c2_t;

  typedef struct packed {
    coord_t [2:0] p;
    logic         pinned;
    cen_t [2:0]   cen;
    diff_t [2:0]  diff;
    md_t          md;
  } c3_t;

  typedef struct packed {
    coord_t [2:0]     p;
    logic             pinned;
    cen_t [2:0]       cen;
    logic [2:0]       dneg;
    mag_t [2:0]       dmag;
    prod_t [2:0]      sq;
    md_t              md;
    logic [MdSqW-1:0] mdsq;
  } c4_t;

  typedef struct packed {
    coord_t [2:0]     p;
    logic             pinned;
    cen_t [2:0]       cen;
    logic [2:0]       dneg;
    mag_t [2:0]       dmag;
    md_t              md;
    logic [MdSqW-1:0] mdsq;
    sum_t             ds;
  } c5_t;

  typedef struct packed {
    coord_t [2:0]      p;
    cen_t [2:0]        cen;
    logic [2:0]        dneg;
    mag_t [2:0]        dmag;
    md_t               md;
    logic              push;
    logic [SqInW-1:0]  x;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_t;

  typedef struct packed {
    coord_t [2:0]          p;
    cen_t [2:0]            cen;
    logic [2:0]            dneg;
    logic                  push;
    logic [RootW-1:0]      e;
    logic [2:0][NumW-1:0]  num;
  } d0_t;

  typedef struct packed {
    coord_t [2:0]           p;
    cen_t [2:0]             cen;
    logic [2:0]             dneg;
    logic                   push;
    logic [RootW-1:0]       e;
    logic [2:0][QRemW-1:0]  rem;
    logic [2:0][QBits-1:0]  low;
    logic [2:0][QBits-1:0]  q;
  } qd_t;

  // Magnitude of a signed value
  function automatic mag_t mag_of(input diff_t x);
    logic [DiffW-1:0] n;
    n = x[DiffW-1] ? (~x + 1'b1) : x;
    return n[MagW-1:0];
  endfunction

  // One restoring step of the fraction divide dot / seg
  function automatic tdiv_t tdiv_step(input tdiv_t c);
    tdiv_t r;
    rem_t  r2;
    logic  ge;
    r  = c;
    r2 = {c.rem[RemW-2:0], 1'b0};
    ge = r2 >= RemW'(c.seg);
    r.rem = ge ? (r2 - RemW'(c.seg)) : r2;
    r.quo = {c.quo[TBits-2:0], ge};
    return r;
  endfunction

  // One digit of the integer square root, two radicand bits a step
  function automatic sq_t sqrt_step(input sq_t c);
    sq_t               r;
    logic [SqRemW-1:0] cur;
    logic [SqRemW-1:0] trial;
    logic              ge;
    r     = c;
    cur   = {c.rem[SqRemW-3:0], c.x[SqInW-1 -: 2]};
    trial = SqRemW'({c.root, 2'b01});
    ge    = cur >= trial;
    r.rem  = ge ? (cur - trial) : cur;
    r.root = {c.root[RootW-2:0], ge};
    r.x    = {c.x[SqInW-3:0], 2'b00};
    return r;
  endfunction

  // One restoring step of the three offset divides by e
  function automatic qd_t qdiv_step(input qd_t c);
    qd_t              r;
    logic [QRemW:0]   cur;
    logic [QRemW:0]   dv;
    logic             ge;
    r  = c;
    dv = (QRemW + 1)'(c.e);
    for (int i = 0; i < 3; i++) begin
      cur = {c.rem[i], c.low[i][QBits-1]};
      ge  = cur >= dv;
      cur = ge ? (cur - dv) : cur;
      r.rem[i] = cur[QRemW-1:0];
      r.low[i] = {c.low[i][QBits-2:0], 1'b0};
      r.q[i]   = {c.q[i][QBits-2:0], ge};
    end
    return r;
  endfunction

  // Centre plus signed offset, saturated to the coordinate range
  function automatic coord_t sat_add(input cen_t cen, input logic neg,
                                     input logic [QBits-1:0] off);
    logic signed [OutSumW-1:0] c;
    logic signed [OutSumW-1:0] o;
    logic signed [OutSumW-1:0] s;
    logic [OutSumW-CoordW:0]   top;
    c   = OutSumW'(cen);
    o   = $signed(OutSumW'(off));
    s   = neg ? (c - o) : (c + o);
    top = s[OutSumW-1:CoordW-1];
    if ((&top) || !(|top)) begin
      return s[CoordW-1:0];
    end
    return s[OutSumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
  endfunction

endpackage

// ----- design/capsule_point_pushout_top.sv -----
// ----------------------------------------------------------------------------
// capsule_point_pushout_top: point against tapered capsule push-out
// Pushes one limb point out of a capsule between two end spheres.
// ----------------------------------------------------------------------------
// Usage
//   in  channel: in_valid_i / in_ready_o, one word per point query.
//   out channel: out_valid_o / out_ready_i, one result word per input word,
//                in input order.
//   cfg channel: cfg_valid_i / cfg_ready_o, writes limb_radius; always
//                ready, to be written only while the block is empty.
//   Throughput: one word per cycle while no result waits on out_ready_i.
//   Depth: NumStages (94) register stages, made up mostly of the 24-step
//   fraction divide, the 31-step square root and the 26-step offset
//   divide, each one step per pipeline stage.
//   Reset: pipeline emptied, limb_radius cleared to 0.
//   Stall: while a result waits on out_ready_i the whole pipeline holds
//   and in_ready_o is low; with no result waiting the block takes a word
//   every cycle.
// ----------------------------------------------------------------------------
module capsule_point_pushout_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpp_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpp_pkg::out_word_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cpp_pkg::rad_t       cfg_data_i
);
  import cpp_pkg::*;

  logic                 en;
  logic [NumStages-1:0] vld_q;
  rad_t                 limb_q;

  st1_t  st1_d, st1_q;
  st2_t  st2_d, st2_q;
  st3_t  st3_d, st3_q;
  tdiv_t td_d [TBits+1];
  tdiv_t td_q [TBits+1];
  c1_t   c1_d, c1_q;
  c2_t   c2_d, c2_q;
  c3_t   c3_d, c3_q;
  c4_t   c4_d, c4_q;
  c5_t   c5_d, c5_q;
  sq_t   sq_d [SqSteps+1];
  sq_t   sq_q [SqSteps+1];
  d0_t   d0_d, d0_q;
  qd_t   qd_d [QBits+1];
  qd_t   qd_q [QBits+1];
  out_word_t out_d, out_q;

  // Pipeline advances unless a result is held at the output
  assign en          = ~vld_q[NumStages-1] | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = out_q;

  // Limb radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limb_q <= '0;
    end else if (cfg_valid_i) begin
      limb_q <= cfg_data_i;
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: segment and point vectors from A
  always_comb begin
    st1_d.ctx.p[0]   = in_data_i.pos_x;
    st1_d.ctx.p[1]   = in_data_i.pos_y;
    st1_d.ctx.p[2]   = in_data_i.pos_z;
    st1_d.ctx.a[0]   = in_data_i.a_x;
    st1_d.ctx.a[1]   = in_data_i.a_y;
    st1_d.ctx.a[2]   = in_data_i.a_z;
    st1_d.ctx.ra     = in_data_i.a_radius;
    st1_d.ctx.rb     = in_data_i.b_radius;
    st1_d.ctx.pinned = in_data_i.pinned;
    st1_d.s[0] = $signed({in_data_i.b_x[CoordW-1], in_data_i.b_x})
               - $signed({in_data_i.a_x[CoordW-1], in_data_i.a_x});
    st1_d.s[1] = $signed({in_data_i.b_y[CoordW-1], in_data_i.b_y})
               - $signed({in_data_i.a_y[CoordW-1], in_data_i.a_y});
    st1_d.s[2] = $signed({in_data_i.b_z[CoordW-1], in_data_i.b_z})
               - $signed({in_data_i.a_z[CoordW-1], in_data_i.a_z});
    st1_d.v[0] = $signed({in_data_i.pos_x[CoordW-1], in_data_i.pos_x})
               - $signed({in_data_i.a_x[CoordW-1], in_data_i.a_x});
    st1_d.v[1] = $signed({in_data_i.pos_y[CoordW-1], in_data_i.pos_y})
               - $signed({in_data_i.a_y[CoordW-1], in_data_i.a_y});
    st1_d.v[2] = $signed({in_data_i.pos_z[CoordW-1], in_data_i.pos_z})
               - $signed({in_data_i.a_z[CoordW-1], in_data_i.a_z});
  end

  // Stage 2: squares of the segment and projection products
  always_comb begin
    mag_t ms, mv;
    st2_d.ctx = st1_q.ctx;
    st2_d.s   = st1_q.s;
    for (int i = 0; i < 3; i++) begin
      ms = mag_of(DiffW'($signed(st1_q.s[i])));
      mv = mag_of(DiffW'($signed(st1_q.v[i])));
      st2_d.sq[i]  = ProdW'(ms) * ProdW'(ms);
      st2_d.pr[i]  = ProdW'(mv) * ProdW'(ms);
      st2_d.prn[i] = st1_q.s[i][SW-1] ^ st1_q.v[i][SW-1];
    end
  end

  // Stage 3: squared segment length and signed dot product
  always_comb begin
    dot_t acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = st2_q.prn[i] ? (acc - $signed(DotW'(st2_q.pr[i])))
                         : (acc + $signed(DotW'(st2_q.pr[i])));
    end
    st3_d.ctx = st2_q.ctx;
    st3_d.s   = st2_q.s;
    st3_d.seg = SumW'(st2_q.sq[0]) + SumW'(st2_q.sq[1]) + SumW'(st2_q.sq[2]);
    st3_d.dot = acc;
  end

  // Stage 4: clamp tests, then the divide chain for the fraction t
  always_comb begin
    logic tz, t1;
    tz = st3_q.dot[DotW-1] || (st3_q.dot == '0);
    t1 = !tz && (st3_q.dot[SumW-1:0] >= st3_q.seg);
    td_d[0].ctx   = st3_q.ctx;
    td_d[0].s     = st3_q.s;
    td_d[0].seg   = st3_q.seg;
    td_d[0].rem   = (tz || t1) ? '0 : RemW'(st3_q.dot[SumW-1:0]);
    td_d[0].quo   = '0;
    td_d[0].degen = st3_q.seg < SumW'(MinDistSq);
    td_d[0].tzero = tz;
    td_d[0].tone  = t1;
    for (int k = 0; k < TBits; k++) begin
      td_d[k+1] = tdiv_step(td_q[k]);
    end
  end

  // Centre and radius products at fraction t
  always_comb begin
    logic [TBits:0] t;
    mag_t           ms;
    rad_t           dr;
    t = td_q[TBits].tone  ? {1'b1, {TBits{1'b0}}} :
        td_q[TBits].tzero ? '0 : {1'b0, td_q[TBits].quo};
    c1_d.ctx   = td_q[TBits].ctx;
    c1_d.degen = td_q[TBits].degen;
    for (int i = 0; i < 3; i++) begin
      ms = mag_of(DiffW'($signed(td_q[TBits].s[i])));
      c1_d.sneg[i] = td_q[TBits].s[i][SW-1];
      c1_d.ofp[i]  = OfpW'(ms) * OfpW'(t) + OfpW'({1'b1, {(TBits-1){1'b0}}});
    end
    c1_d.rbge = td_q[TBits].ctx.rb >= td_q[TBits].ctx.ra;
    dr = c1_d.rbge ? (td_q[TBits].ctx.rb - td_q[TBits].ctx.ra)
                   : (td_q[TBits].ctx.ra - td_q[TBits].ctx.rb);
    c1_d.rp = RpW'(dr) * RpW'(t);
  end

  // Closest centre and capsule radius; short segment falls back to A
  always_comb begin
    mag_t  off;
    diff_t cf;
    rad_t  rdel;
    c2_d.p      = c1_q.ctx.p;
    c2_d.pinned = c1_q.ctx.pinned;
    for (int i = 0; i < 3; i++) begin
      off = c1_q.ofp[i][TBits +: MagW];
      cf  = c1_q.sneg[i] ? (DiffW'($signed(c1_q.ctx.a[i])) - $signed({1'b0, off}))
                         : (DiffW'($signed(c1_q.ctx.a[i])) + $signed({1'b0, off}));
      c2_d.cen[i] = c1_q.degen ? CenW'($signed(c1_q.ctx.a[i])) : cf[CenW-1:0];
    end
    rdel = c1_q.rp[TBits +: RadW];
    c2_d.rad = c1_q.degen ? c1_q.ctx.ra
             : (c1_q.rbge ? (c1_q.ctx.ra + rdel) : (c1_q.ctx.ra - rdel));
  end

  // Offset from centre and contact distance
  always_comb begin
    c3_d.p      = c2_q.p;
    c3_d.pinned = c2_q.pinned;
    c3_d.cen    = c2_q.cen;
    for (int i = 0; i < 3; i++) begin
      c3_d.diff[i] = DiffW'($signed(c2_q.p[i])) - DiffW'($signed(c2_q.cen[i]));
    end
    c3_d.md = MdW'(limb_q) + MdW'(c2_q.rad);
  end

  // Squares of the offset and of the contact distance
  always_comb begin
    c4_d.p      = c3_q.p;
    c4_d.pinned = c3_q.pinned;
    c4_d.cen    = c3_q.cen;
    c4_d.md     = c3_q.md;
    c4_d.mdsq   = MdSqW'(c3_q.md) * MdSqW'(c3_q.md);
    for (int i = 0; i < 3; i++) begin
      c4_d.dneg[i] = c3_q.diff[i][DiffW-1];
      c4_d.dmag[i] = mag_of(c3_q.diff[i]);
      c4_d.sq[i]   = ProdW'(c4_d.dmag[i]) * ProdW'(c4_d.dmag[i]);
    end
  end

  // Squared distance
  always_comb begin
    c5_d.p      = c4_q.p;
    c5_d.pinned = c4_q.pinned;
    c5_d.cen    = c4_q.cen;
    c5_d.dneg   = c4_q.dneg;
    c5_d.dmag   = c4_q.dmag;
    c5_d.md     = c4_q.md;
    c5_d.mdsq   = c4_q.mdsq;
    c5_d.ds     = SumW'(c4_q.sq[0]) + SumW'(c4_q.sq[1]) + SumW'(c4_q.sq[2]);
  end

  // Contact decision, then the square root chain for the distance
  always_comb begin
    sq_d[0].p    = c5_q.p;
    sq_d[0].cen  = c5_q.cen;
    sq_d[0].dneg = c5_q.dneg;
    sq_d[0].dmag = c5_q.dmag;
    sq_d[0].md   = c5_q.md;
    sq_d[0].push = !c5_q.pinned && (c5_q.ds < SumW'(c5_q.mdsq))
                   && (c5_q.ds >= SumW'(MinDistSq));
    sq_d[0].x    = {c5_q.ds[MdSqW-1:0], {SqShift{1'b0}}};
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
    for (int k = 0; k < SqSteps; k++) begin
      sq_d[k+1] = sqrt_step(sq_q[k]);
    end
  end

  // Scaled offset numerators
  always_comb begin
    d0_d.p    = sq_q[SqSteps].p;
    d0_d.cen  = sq_q[SqSteps].cen;
    d0_d.dneg = sq_q[SqSteps].dneg;
    d0_d.push = sq_q[SqSteps].push;
    d0_d.e    = sq_q[SqSteps].root;
    for (int i = 0; i < 3; i++) begin
      d0_d.num[i] = NumW'(sq_q[SqSteps].dmag[i][MdW-1:0]) * NumW'(sq_q[SqSteps].md);
    end
  end

  // Rounding term, then the offset divide chain
  always_comb begin
    logic [NnW-1:0] nn;
    qd_d[0].p    = d0_q.p;
    qd_d[0].cen  = d0_q.cen;
    qd_d[0].dneg = d0_q.dneg;
    qd_d[0].push = d0_q.push;
    qd_d[0].e    = d0_q.e;
    for (int i = 0; i < 3; i++) begin
      nn = NnW'({d0_q.num[i], {OffFrac{1'b0}}}) + NnW'(d0_q.e[RootW-1:1]);
      qd_d[0].rem[i] = nn[NnW-1:QBits];
      qd_d[0].low[i] = nn[QBits-1:0];
      qd_d[0].q[i]   = '0;
    end
    for (int k = 0; k < QBits; k++) begin
      qd_d[k+1] = qdiv_step(qd_q[k]);
    end
  end

  // Resolved point
  always_comb begin
    coord_t [2:0] np;
    for (int i = 0; i < 3; i++) begin
      np[i] = qd_q[QBits].push
            ? sat_add(qd_q[QBits].cen[i], qd_q[QBits].dneg[i], qd_q[QBits].q[i])
            : qd_q[QBits].p[i];
    end
    out_d.new_x  = np[0];
    out_d.new_y  = np[1];
    out_d.new_z  = np[2];
    out_d.pushed = qd_q[QBits].push;
  end

  // Stage data registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      for (int k = 0; k <= TBits; k++) begin
        td_q[k] <= td_d[k];
      end
      c1_q <= c1_d;
      c2_q <= c2_d;
      c3_q <= c3_d;
      c4_q <= c4_d;
      c5_q <= c5_d;
      for (int k = 0; k <= SqSteps; k++) begin
        sq_q[k] <= sq_d[k];
      end
      d0_q <= d0_d;
      for (int k = 0; k <= QBits; k++) begin
        qd_q[k] <= qd_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule

// ----- design/cpp_checker.sv -----
// ----------------------------------------------------------------------------
// cpp_checker: port-level checks of the capsule point push-out
// Watches the channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module cpp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input cpp_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cpp_pkg::out_word_t out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input cpp_pkg::rad_t      cfg_data_i
);

  // A stalled result word stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // A refused input word stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word withdrawn or changed while waiting");

  // With no result waiting the input side must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Out of reset nothing is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered straight after reset");

  // Configuration writes are never refused and carry known data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o && !$isunknown(cfg_data_i))
    else $error("configuration write refused");

endmodule

bind capsule_point_pushout_top cpp_checker u_cpp_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for capsule_point_pushout_top
// Streams point/capsule queries through the block under random valid and
// ready gaps, predicts each resolved point and compares it word by word.
// limb_radius is changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
  import cpp_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned PipeDepth = 94;
  localparam int unsigned StallLimit = 5000;
  localparam longint MinSq = 429497;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  rad_t      cfg_data = '0;

  in_word_t  query_q[$];
  out_word_t resolved_q[$];
  rad_t      limb_mirror = '0;
  logic      calm = 1'b0;
  int        errors = 0;
  int        quiet_cycles = 0;

  always #1 clk = ~clk;

  capsule_point_pushout_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // Integer square root, two radicand bits per digit
  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic wide_t clamp32(input wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // Sphere test against centre c; returns 1 when the point is moved
  function automatic logic sphere_push(input wide_t p[3], input wide_t c[3],
                                       input wide_t rad, input wide_t limb,
                                       output wide_t np[3]);
    wide_t d[3];
    wide_t ds;
    wide_t md;
    wide_t e;
    wide_t mg;
    wide_t off;
    ds = 0;
    md = limb + rad;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - c[i];
      ds += d[i] * d[i];
      np[i] = p[i];
    end
    if (ds >= md * md || ds < MinSq) return 1'b0;
    e = root64(64'(ds) << 12);
    for (int i = 0; i < 3; i++) begin
      mg  = d[i] < 0 ? -d[i] : d[i];
      off = ((mg * md) * 64 + e / 2) / e;
      np[i] = clamp32(d[i] < 0 ? c[i] - off : c[i] + off);
    end
    return 1'b1;
  endfunction

  // Expected resolved point for one query under the given limb radius
  function automatic out_word_t pushout_predict(input in_word_t w, input rad_t limb);
    wide_t p[3], a[3], b[3], s[3], cen[3], np[3];
    wide_t ra, rb, rad, seg, dot, t, ms, off, lw;
    logic  moved;
    out_word_t r;
    p = '{wide_t'(w.pos_x), wide_t'(w.pos_y), wide_t'(w.pos_z)};
    a = '{wide_t'(w.a_x), wide_t'(w.a_y), wide_t'(w.a_z)};
    b = '{wide_t'(w.b_x), wide_t'(w.b_y), wide_t'(w.b_z)};
    ra = {104'd0, w.a_radius};
    rb = {104'd0, w.b_radius};
    lw = {104'd0, limb};
    np = p;
    moved = 1'b0;
    if (!w.pinned) begin
      seg = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        s[i] = b[i] - a[i];
        seg += s[i] * s[i];
        dot += (p[i] - a[i]) * s[i];
      end
      if (seg < MinSq) begin
        moved = sphere_push(p, a, ra, lw, np);
      end else begin
        // fraction along the segment, clamped to 0..1
        if (dot <= 0) t = 0;
        else if (dot >= seg) t = wide_t'(1) << 24;
        else t = (dot <<< 24) / seg;
        for (int i = 0; i < 3; i++) begin
          ms  = s[i] < 0 ? -s[i] : s[i];
          off = (ms * t + (wide_t'(1) << 23)) >>> 24;
          cen[i] = s[i] < 0 ? a[i] - off : a[i] + off;
        end
        if (rb >= ra) rad = ra + (((rb - ra) * t) >>> 24);
        else rad = ra - (((ra - rb) * t) >>> 24);
        moved = sphere_push(p, cen, rad, lw, np);
      end
    end
    r.new_x  = coord_t'(np[0]);
    r.new_y  = coord_t'(np[1]);
    r.new_z  = coord_t'(np[2]);
    r.pushed = moved;
    return r;
  endfunction

  // Driver: one word held until taken, random gaps unless calm
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      resolved_q.push_back(pushout_predict(in_data, limb_mirror));
    end
    if (!in_valid || in_ready) begin
      if (query_q.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        in_valid <= 1'b1;
        in_data  <= query_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure and word compare
  always @(posedge clk) begin
    out_word_t want;
    out_ready <= calm || ($urandom_range(99) >= 33);
    if (out_valid && out_ready) begin
      if (resolved_q.size() == 0) begin
        $error("unexpected result word %h", out_data);
        errors++;
      end else begin
        want = resolved_q.pop_front();
        if (out_data.new_x !== want.new_x) begin
          $error("new_x: expected %h, got %h", want.new_x, out_data.new_x);
          errors++;
        end
        if (out_data.new_y !== want.new_y) begin
          $error("new_y: expected %h, got %h", want.new_y, out_data.new_y);
          errors++;
        end
        if (out_data.new_z !== want.new_z) begin
          $error("new_z: expected %h, got %h", want.new_z, out_data.new_z);
          errors++;
        end
        if (out_data.pushed !== want.pushed) begin
          $error("pushed: expected %b, got %b", want.pushed, out_data.pushed);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** capsule_point_pushout_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_limb(input rad_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    limb_mirror = val;
    cfg_valid <= 1'b0;
  endtask

  // Wait for the pipeline to empty, then let it settle
  task automatic drain(input int extra);
    do @(negedge clk);
    while (query_q.size() != 0 || in_valid || resolved_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  function automatic in_word_t build(input coord_t p[3], input logic pin,
                                     input coord_t a[3], input rad_t ra,
                                     input coord_t b[3], input rad_t rb);
    in_word_t w;
    w.pos_x = p[0]; w.pos_y = p[1]; w.pos_z = p[2];
    w.pinned = pin;
    w.a_x = a[0]; w.a_y = a[1]; w.a_z = a[2]; w.a_radius = ra;
    w.b_x = b[0]; w.b_y = b[1]; w.b_z = b[2]; w.b_radius = rb;
    return w;
  endfunction

  // Random query: mostly a point near a capsule, else noise
  function automatic in_word_t random_query();
    in_word_t w;
    logic [351:0] raw;
    coord_t a[3], b[3], p[3];
    longint span, jit, frac;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(in_word_t)-1:0];
      return w;
    end
    span = (pick < 25) ? 2 : (64'd1 << $urandom_range(4, 26));
    jit  = 64'd1 << $urandom_range(4, 25);
    frac = $urandom_range(0, 1200);
    for (int i = 0; i < 3; i++) begin
      a[i] = ($urandom_range(9) == 0) ? coord_t'({$urandom_range(1), 31'h7fff_f000} ^
             {1'b0, 31'($urandom_range(4095))}) : coord_t'($urandom);
      b[i] = coord_t'(longint'(a[i]) + longint'($urandom_range(0, 2 * span)) - span);
      p[i] = coord_t'(longint'(a[i]) + (longint'(b[i]) - longint'(a[i])) * frac / 1000
             + longint'($urandom_range(0, 2 * jit)) - jit - 100);
    end
    w = build(p, $urandom_range(19) == 0, a, rad_t'($urandom >> $urandom_range(0, 16)),
              b, rad_t'($urandom >> $urandom_range(0, 16)));
    return w;
  endfunction

  // Directed corners: pinned, degenerate, overlap, no contact, clamps, taper, saturation
  task automatic directed_set();
    coord_t o[3], a[3], b[3], p[3], mx[3], mn[3];
    o  = '{0, 0, 0};
    mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    a  = '{0, 0, 0};
    b  = '{32'sh0010_0000, 0, 0};
    p  = '{32'sh0008_0000, 32'sh0000_4000, 0};
    query_q.push_back(build(p, 1'b1, a, 24'h08_0000, b, 24'h08_0000));
    query_q.push_back(build(p, 1'b0, a, 24'h08_0000, b, 24'h08_0000));
    query_q.push_back(build(p, 1'b0, a, 24'h01_0000, b, 24'hff_ffff));
    query_q.push_back(build(p, 1'b0, a, 24'hff_ffff, b, 24'h00_0000));
    query_q.push_back(build('{-32'sh0004_0000, 1000, 0}, 1'b0, a, 24'h08_0000, b,
                            24'h02_0000));
    query_q.push_back(build('{32'sh0014_0000, 0, 32'sh100}, 1'b0, a, 24'h02_0000, b,
                            24'h08_0000));
    query_q.push_back(build('{5, 0, 0}, 1'b0, a, 24'h08_0000, b, 24'h08_0000));
    query_q.push_back(build('{32'sh0000_8000, 7, 0}, 1'b0, o, 24'h01_0000, o, 24'h0));
    query_q.push_back(build(o, 1'b0, o, 24'hff_ffff, o, 24'hff_ffff));
    query_q.push_back(build('{32'sh0100_0000, 0, 0}, 1'b0, a, 24'h00_0100, b, 24'h00_0100));
    query_q.push_back(build(p, 1'b0, a, 24'h0, b, 24'h0));
    query_q.push_back(build('{32'sh7fff_fff0, 0, 0}, 1'b0, '{32'sh7fff_f000, 0, 0},
                            24'hff_ffff, '{32'sh7fff_f000, 0, 0}, 24'hff_ffff));
    query_q.push_back(build('{32'sh8000_0010, 0, 0}, 1'b0, '{32'sh8000_1000, 0, 0},
                            24'hff_ffff, '{32'sh8000_1000, 0, 0}, 24'hff_ffff));
    query_q.push_back(build(mx, 1'b0, mn, 24'hff_ffff, mx, 24'hff_ffff));
    query_q.push_back(build(mn, 1'b0, mx, 24'hff_ffff, mn, 24'h0));
    query_q.push_back(build(mx, 1'b1, mx, 24'hff_ffff, mx, 24'hff_ffff));
    query_q.push_back(build('{-1, -1, -1}, 1'b0, '{1, 1, 1}, 24'hff_ffff, '{1, 1, 1},
                            24'hff_ffff));
  endtask

  initial begin
    rad_t limbs[6];
    limbs = '{24'h0, 24'hff_ffff, 24'h01_0000, 24'h00_0001, 24'h40_0000, 24'h0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_limb(ph == 5 ? rad_t'($urandom) : limbs[ph]);
      calm = (ph == 3);
      directed_set();
      for (int k = 0; k < 140; k++) query_q.push_back(random_query());
      drain(PipeDepth + 6);
    end
    if (errors == 0) begin
      $display("** capsule_point_pushout_top: PASSED **");
    end else begin
      $display("** capsule_point_pushout_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cpp_pkg.sv
design/capsule_point_pushout_top.sv
design/cpp_checker.sv
sim/tb.sv
